// ----- sv/rfc_pkg.sv -----
`default_nettype none

package rfc_pkg;

    localparam logic [31:0] CRC_POLY   = 32'h82f6_3b78;
    localparam logic [31:0] CRC_PRESET = 32'hffff_ffff;
    localparam logic [31:0] MASK_DELTA = 32'ha282_ead8;

    // command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    // emission steps within one command
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] HDR_LEN_LAST  = 4'd3;   // last byte taken from record_length
    localparam logic [STEP_W-1:0] HDR_PAD_LAST  = 4'd7;   // last byte of the length word
    localparam logic [STEP_W-1:0] HDR_CRC_LAST  = 4'd11;  // last header crc byte
    localparam logic [STEP_W-1:0] TRL_CRC_LAST  = 4'd4;   // last data crc byte

    typedef enum logic [1:0] {
        CMD_START = 2'b00,   // header of a new record, data holds the length
        CMD_BYTE  = 2'b01,   // plain payload byte
        CMD_LAST  = 2'b10,   // closing payload byte, data holds the final crc
        CMD_ERR   = 2'b11    // payload byte with no record open
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] data;
        logic [7:0]  pbyte;
    } cmd_t;

    // reflected crc-32c, one byte folded in
    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    // final xor, rotate right by 15, add delta
    function automatic logic [31:0] crc_mask(input logic [31:0] crc);
        logic [31:0] x;
        x = crc ^ CRC_PRESET;
        return {x[14:0], x[31:15]} + MASK_DELTA;
    endfunction

    function automatic logic [7:0] byte_sel(input logic [31:0] w, input logic [1:0] idx);
        return w[{idx, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// ----- sv/rfc_queue.sv -----
`default_nettype none

module rfc_queue
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire rfc_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output rfc_pkg::cmd_t      head,
    output logic               empty
);
    import rfc_pkg::*;

    cmd_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // fill level tracks the pointer distance
    a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == Q_CNT_W'(Q_DEPTH)) || (Q_PTR_W'(count_reg) == wr_ptr_reg - rd_ptr_reg))
        else $error("queue count disagrees with pointers");

endmodule

`default_nettype wire

// ----- sv/rfc_front.sv -----
`default_nettype none

module rfc_front
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        mode,
    input  wire logic [31:0] record_length,
    input  wire logic [7:0]  payload_byte,
    output logic             push,
    output rfc_pkg::cmd_t    push_cmd,
    input  wire logic        q_full
);
    import rfc_pkg::*;

    logic [31:0] running_crc_reg, running_crc_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic        record_open_reg, record_open_next;
    logic        accept;
    logic [31:0] crc_upd;
    logic [31:0] left_upd;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign crc_upd  = crc_fold(running_crc_reg, payload_byte);
    assign left_upd = bytes_left_reg - 32'd1;

    always_comb
    begin
        running_crc_next  = running_crc_reg;
        bytes_left_next   = bytes_left_reg;
        record_open_next  = record_open_reg;
        push              = 1'b0;
        push_cmd.kind     = CMD_ERR;
        push_cmd.data     = record_length;
        push_cmd.pbyte    = payload_byte;
        if (accept)
        begin
            if (!mode)
            begin
                // zero length start does nothing
                if (record_length != 32'd0)
                begin
                    push             = 1'b1;
                    push_cmd.kind    = CMD_START;
                    running_crc_next = CRC_PRESET;
                    bytes_left_next  = record_length;
                    record_open_next = 1'b1;
                end
            end
            else if (!record_open_reg)
            begin
                push          = 1'b1;
                push_cmd.kind = CMD_ERR;
            end
            else
            begin
                push            = 1'b1;
                bytes_left_next = left_upd;
                if (left_upd != 32'd0)
                begin
                    push_cmd.kind    = CMD_BYTE;
                    running_crc_next = crc_upd;
                end
                else
                begin
                    push_cmd.kind    = CMD_LAST;
                    push_cmd.data    = crc_upd;
                    running_crc_next = CRC_PRESET;
                    record_open_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_crc_reg <= CRC_PRESET;
            bytes_left_reg  <= '0;
            record_open_reg <= 1'b0;
        end
        else
        begin
            running_crc_reg <= running_crc_next;
            bytes_left_reg  <= bytes_left_next;
            record_open_reg <= record_open_next;
        end
    end

    // an open record always has bytes still to come
    a_open_left: assert property (@(posedge clk) disable iff (!rst_n)
        record_open_reg |-> (bytes_left_reg != 32'd0))
        else $error("open record with no bytes left");

endmodule

`default_nettype wire

// ----- sv/rfc_back.sv -----
`default_nettype none

module rfc_back
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire rfc_pkg::cmd_t head,
    input  wire logic          q_empty,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [7:0]         out_byte,
    output logic               run_last,
    output logic               record_end,
    output logic               frame_error
);
    import rfc_pkg::*;

    logic [STEP_W-1:0] step_reg, step_next;
    logic [31:0]       hcrc_reg, hcrc_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg;
    logic              run_last_reg, record_end_reg, frame_error_reg;

    logic              emit;
    logic [7:0]        res_byte;
    logic              res_last, res_end, res_err;
    logic [31:0]       hdr_masked, trl_masked;
    logic [1:0]        trl_idx;

    assign emit       = !q_empty && (!out_valid_reg || !out_stall);
    assign hdr_masked = crc_mask(hcrc_reg);
    assign trl_masked = crc_mask(head.data);
    assign trl_idx    = 2'(step_reg - STEP_W'(1));

    always_comb
    begin
        res_byte  = 8'd0;
        res_last  = 1'b0;
        res_end   = 1'b0;
        res_err   = 1'b0;
        hcrc_next = hcrc_reg;
        case (head.kind)
            CMD_START:
            begin
                if (step_reg <= HDR_PAD_LAST)
                begin
                    res_byte  = (step_reg <= HDR_LEN_LAST) ?
                                byte_sel(head.data, step_reg[1:0]) : 8'd0;
                    hcrc_next = crc_fold(hcrc_reg, res_byte);
                end
                else
                begin
                    res_byte = byte_sel(hdr_masked, step_reg[1:0]);
                    res_last = (step_reg == HDR_CRC_LAST);
                    if (res_last)
                    begin
                        hcrc_next = CRC_PRESET;
                    end
                end
            end
            CMD_BYTE:
            begin
                res_byte = head.pbyte;
                res_last = 1'b1;
            end
            CMD_LAST:
            begin
                if (step_reg == '0)
                begin
                    res_byte = head.pbyte;
                end
                else
                begin
                    res_byte = byte_sel(trl_masked, trl_idx);
                    res_last = (step_reg == TRL_CRC_LAST);
                    res_end  = res_last;
                end
            end
            CMD_ERR:
            begin
                res_err  = 1'b1;
                res_last = 1'b1;
            end
            default:
            begin
                res_err  = 1'b1;
                res_last = 1'b1;
            end
        endcase
    end

    assign pop = emit && res_last;

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (emit)
        begin
            out_valid_next = 1'b1;
            step_next      = res_last ? '0 : step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            hcrc_reg      <= CRC_PRESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (emit)
            begin
                hcrc_reg <= hcrc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg    <= res_byte;
            run_last_reg    <= res_last;
            record_end_reg  <= res_end;
            frame_error_reg <= res_err;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign run_last    = run_last_reg;
    assign record_end  = record_end_reg;
    assign frame_error = frame_error_reg;

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= HDR_CRC_LAST)
        else $error("emission step out of range");

    a_step_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != '0) |-> !q_empty)
        else $error("mid-command step with empty queue");

    a_hcrc_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == '0) |-> (hcrc_reg == CRC_PRESET))
        else $error("header crc not reset between commands");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!record_end_reg || run_last_reg) &&
                          (!frame_error_reg || (run_last_reg && out_byte_reg == 8'd0)))
        else $error("inconsistent result flags");

endmodule

`default_nettype wire

// ----- sv/record_framer_crc32c.sv -----
// record_framer_crc32c: length-prefixed record framing with masked crc-32c
//
// input channel (in_valid / in_stall): one item per handshake. mode 0 starts a
//   record of record_length payload bytes, mode 1 carries one payload_byte.
// output channel (out_valid / out_stall): one framed byte per handshake, with
//   run_last on the last result of each input item, record_end on the final
//   data crc byte and frame_error on a payload byte that had no open record.
// a start gives 12 results (8 length bytes, 4 header crc bytes), an ordinary
//   payload byte 1, the closing payload byte 5, a stray payload byte 1; a start
//   of length zero gives none.
// path: an accepted item is written into the command queue, and its first
//   result is then registered in the output register before it reaches the ports.
// throughput: one payload byte per cycle while in_stall is low; the back end
//   emits one result per cycle unless out_stall holds it or the queue is empty.
//   a 4-entry command queue sits between the front and back end; in_stall
//   rises only when that queue is full.
// out_stall holds the output register and its payload; the queue keeps
//   filling until full, then in_stall is raised.
// reset (rst_n low, asynchronous) closes any record, empties the queue and
//   drops out_valid; both crc registers return to all ones.

`default_nettype none

module record_framer_crc32c
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        mode,
    input  wire logic [31:0] record_length,
    input  wire logic [7:0]  payload_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             run_last,
    output logic             record_end,
    output logic             frame_error
);
    import rfc_pkg::*;

    // front to queue
    logic push;
    cmd_t push_cmd;
    logic q_full;

    // queue to back
    cmd_t head;
    logic q_empty;
    logic pop;

    // classifies items, keeps record state and the running data crc
    rfc_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .record_length (record_length),
        .payload_byte  (payload_byte),
        .push          (push),
        .push_cmd      (push_cmd),
        .q_full        (q_full)
    );

    // short command queue decoupling the two halves
    rfc_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty)
    );

    // expands each command into framed bytes, header crc folded on the fly
    rfc_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_empty     (q_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .record_end  (record_end),
        .frame_error (frame_error)
    );

endmodule

`default_nettype wire
